// ===== rtl/bbd_pkg.sv =====
// Shared types and constants of the Bayer bilinear demosaic block.
package bbd_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic             shift;        // push a new column into the window
        logic             restart;      // clear the window, frame done
        logic             emit;         // item produces a pixel
        logic             after_shift;  // pixel taken from the shifted window
        logic             row_odd;
        logic             col_odd;
        logic             top_edge;     // replicate middle row upward
        logic             bot_edge;     // replicate middle row downward
        logic             left_rep;     // replicate center column leftward
        logic             last;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } q_entry_t;

endpackage

// ===== rtl/bbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bbd_front.sv =====
// Front end: input acceptance, raster position tracking, line stores, item classification.
module bbd_front import bbd_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cfg_clear,
    input  logic [QCNT_W-1:0]     q_count,
    output logic                  q_push,
    output q_entry_t              q_wdata
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int W_RESET = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
    localparam int H_RESET = (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RESET;

    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic          s1_valid_reg, s1_valid_next;
    q_entry_t      s1_entry_reg, s1_entry_next;
    logic [AW-1:0] s1_addr_reg;

    logic          accept, take, do_shift, do_restart, emit_a, emit_b;
    logic          col_zero, col_last, r_ge_h, r_le_h;
    logic [RW-1:0] h_ext;
    logic [WW-1:0] w_cfg;
    logic [HW-1:0] h_cfg;
    logic          cfg_wr;
    logic [PIX_W-1:0] older_rd, recent_rd;
    logic          store_we;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign cfg_clear = cfg_wr &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    assign s_tready = (q_count + QCNT_W'(s1_valid_reg)) < QCNT_W'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    assign h_ext    = RW'(h_reg);
    assign col_zero = (col_reg == '0);
    assign col_last = (WW'(col_reg) + WW'(1)) == w_reg;
    assign r_ge_h   = row_reg >= h_ext;
    assign r_le_h   = row_reg <= h_ext;

    // Samples count only inside the frame, drains only after its last sample.
    assign take       = accept && (s_tuser ? r_ge_h : !r_ge_h);
    assign do_shift   = take && r_le_h;
    assign do_restart = take && !r_le_h;
    assign emit_a     = take && col_zero && (row_reg >= RW'(2));
    assign emit_b     = do_shift && !col_zero && (row_reg >= RW'(1));

    always_comb begin
        if (cfg_data < CFG_DATA_W'(2)) begin
            w_cfg = WW'(2);
            h_cfg = HW'(2);
        end else begin
            w_cfg = (32'(cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
            h_cfg = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
        end
    end

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        s1_valid_next = take;

        s1_entry_next             = '0;
        s1_entry_next.shift       = do_shift;
        s1_entry_next.restart     = do_restart;
        s1_entry_next.emit        = emit_a || emit_b;
        s1_entry_next.after_shift = emit_b;
        s1_entry_next.bot         = s_tuser ? '0 : s_tdata;
        if (emit_b) begin
            s1_entry_next.top_edge = (row_reg == RW'(1));
            s1_entry_next.bot_edge = (row_reg == h_ext);
            s1_entry_next.row_odd  = ~row_reg[0];
            s1_entry_next.col_odd  = ~col_reg[0];
            s1_entry_next.left_rep = (col_reg == AW'(1));
        end else begin
            // Last pixel of the previous row, right edge replicated.
            s1_entry_next.top_edge = (row_reg == RW'(2));
            s1_entry_next.bot_edge = (row_reg == h_ext + RW'(1));
            s1_entry_next.row_odd  = row_reg[0];
            s1_entry_next.col_odd  = ~w_reg[0];
            s1_entry_next.last     = (row_reg == h_ext + RW'(1));
        end

        if (do_shift) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end else if (do_restart) begin
            col_next = '0;
            row_next = '0;
        end

        if (cfg_wr) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  w_next = w_cfg;
                REG_IMAGE_HEIGHT: h_next = h_cfg;
                default: ;
            endcase
        end
        if (cfg_clear) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            w_reg        <= WW'(W_RESET);
            h_reg        <= HW'(H_RESET);
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            s1_valid_reg <= s1_valid_next;
        end
        s1_entry_reg <= s1_entry_next;
        if (do_shift) begin
            s1_addr_reg <= col_reg;
        end
    end

    // Read both rows when a shift is taken, write them back in the cycle after.
    assign store_we = s1_valid_reg && s1_entry_reg.shift;

    bbd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_row (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (s1_addr_reg),
        .wdata (recent_rd),
        .re    (do_shift),
        .raddr (col_reg),
        .rdata (older_rd)
    );

    bbd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_recent_row (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (s1_addr_reg),
        .wdata (s1_entry_reg.bot),
        .re    (do_shift),
        .raddr (col_reg),
        .rdata (recent_rd)
    );

    assign q_push = s1_valid_reg;

    always_comb begin
        q_wdata     = s1_entry_reg;
        q_wdata.top = older_rd;
        q_wdata.mid = recent_rd;
    end

endmodule

// ===== rtl/bbd_queue.sv =====
// Short FIFO of classified items between front and back.
module bbd_queue import bbd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  q_entry_t          wdata,
    input  logic              pop,
    output logic              rvalid,
    output q_entry_t          rdata,
    output logic [QCNT_W-1:0] count
);

    q_entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign do_pop = pop && (count_reg != '0);
    assign rvalid = (count_reg != '0);
    assign rdata  = slots_reg[rptr_reg];
    assign count  = count_reg;

    always_comb begin
        wptr_next  = push   ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            slots_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/bbd_back.sv =====
// Back end: neighborhood window, bilinear interpolation and output register.
module bbd_back import bbd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_clear,
    input  logic                 q_valid,
    input  q_entry_t             q_rdata,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [3*PIX_W-1:0]   m_tdata,
    output logic                 m_tlast
);

    logic [PIX_W-1:0] win1_reg [3];
    logic [PIX_W-1:0] win2_reg [3];
    logic [PIX_W-1:0] incoming [3];
    logic [PIX_W-1:0] lft [3];
    logic [PIX_W-1:0] ctr [3];
    logic [PIX_W-1:0] rgt [3];

    logic [PIX_W-1:0] ul, u, ur, l, c, r, dl, d, dr;
    logic [PIX_W+1:0] cross_sum, diag_sum;
    logic [PIX_W:0]   horiz_sum, vert_sum;

    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] red_reg, green_reg, blue_reg;
    logic [PIX_W-1:0] red_next, green_next, blue_next;
    logic             last_reg;

    assign q_pop = q_valid && (!m_valid_reg || m_tready);

    assign incoming[0] = q_rdata.top;
    assign incoming[1] = q_rdata.mid;
    assign incoming[2] = q_rdata.bot;

    // Pick the 3x3 neighborhood: before the shift, or as it stands after it.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (q_rdata.after_shift) begin
                lft[i] = q_rdata.left_rep ? win2_reg[i] : win1_reg[i];
                ctr[i] = win2_reg[i];
                rgt[i] = incoming[i];
            end else begin
                lft[i] = win1_reg[i];
                ctr[i] = win2_reg[i];
                rgt[i] = win2_reg[i];
            end
        end
    end

    always_comb begin
        l  = lft[1];
        c  = ctr[1];
        r  = rgt[1];
        ul = q_rdata.top_edge ? lft[1] : lft[0];
        u  = q_rdata.top_edge ? ctr[1] : ctr[0];
        ur = q_rdata.top_edge ? rgt[1] : rgt[0];
        dl = q_rdata.bot_edge ? lft[1] : lft[2];
        d  = q_rdata.bot_edge ? ctr[1] : ctr[2];
        dr = q_rdata.bot_edge ? rgt[1] : rgt[2];
    end

    assign cross_sum = (PIX_W+2)'(l) + (PIX_W+2)'(r) + (PIX_W+2)'(u) + (PIX_W+2)'(d);
    assign diag_sum  = (PIX_W+2)'(ul) + (PIX_W+2)'(ur) + (PIX_W+2)'(dl) + (PIX_W+2)'(dr);
    assign horiz_sum = (PIX_W+1)'(l) + (PIX_W+1)'(r);
    assign vert_sum  = (PIX_W+1)'(u) + (PIX_W+1)'(d);

    always_comb begin
        case ({q_rdata.row_odd, q_rdata.col_odd})
            2'b00: begin
                red_next   = c;
                green_next = cross_sum[PIX_W+1:2];
                blue_next  = diag_sum[PIX_W+1:2];
            end
            2'b01: begin
                red_next   = horiz_sum[PIX_W:1];
                green_next = c;
                blue_next  = vert_sum[PIX_W:1];
            end
            2'b10: begin
                red_next   = vert_sum[PIX_W:1];
                green_next = c;
                blue_next  = horiz_sum[PIX_W:1];
            end
            default: begin
                red_next   = diag_sum[PIX_W+1:2];
                green_next = cross_sum[PIX_W+1:2];
                blue_next  = c;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop && q_rdata.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                win1_reg[i] <= '0;
                win2_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_clear || (q_pop && q_rdata.restart)) begin
                for (int i = 0; i < 3; i++) begin
                    win1_reg[i] <= '0;
                    win2_reg[i] <= '0;
                end
            end else if (q_pop && q_rdata.shift) begin
                for (int i = 0; i < 3; i++) begin
                    win1_reg[i] <= win2_reg[i];
                    win2_reg[i] <= incoming[i];
                end
            end
        end
        if (q_pop && q_rdata.emit) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            last_reg  <= q_rdata.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/bayer_bilinear_demosaic.sv =====
// Top level of the RGGB Bayer bilinear demosaic block.
//
//   channel | direction | handshake              | payload
//   s_      | in        | s_tvalid / s_tready    | tdata raw sample, tuser drain flag
//   m_      | out       | m_tvalid / m_tready    | tdata red, green, blue; tlast frame end
//   cfg_    | in        | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// One item per cycle while the queue has room; each line store does one read and one
// write per cycle. A pixel leaves W+1 raster positions after its sample; m_tvalid
// follows acceptance through the store read stage, the queue and the output register.
// Reset restores 640x480 and the frame start; the line stores are not cleared.
// A stalled output fills the four-entry queue; s_tready drops once queue plus the
// item in the read stage reach four.
module bayer_bilinear_demosaic import bbd_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,    // [7:0] raw_sample
    input  logic                  s_tuser,    // [0] action (drain)
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*PIX_W-1:0]    m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              cfg_clear;
    logic [QCNT_W-1:0] q_count;
    logic              q_push, q_pop, q_valid;
    q_entry_t          q_wdata, q_rdata;

    bbd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_clear (cfg_clear),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    bbd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata),
        .count   (q_count)
    );

    bbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_clear (cfg_clear),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== tb/demosaic_scoreboard_pkg.sv =====
// Pixel predictor and result scoreboard for the Bayer demosaic testbench.
package demosaic_scoreboard_pkg;
    import bbd_pkg::*;

    localparam int DIM_LIMIT    = 4096;
    localparam int REPORT_LIMIT = 40;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } pixel_t;

    class demosaic_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        logic [PIX_W-1:0]      older_row [DIM_LIMIT];
        logic [PIX_W-1:0]      recent_row [DIM_LIMIT];
        logic [PIX_W-1:0]      win [9];    // 3x3 window, row-major: top, middle, bottom
        int                    in_col;
        int                    in_row;
        pixel_t                pending_pixels [$];
        int                    pixels_checked;
        int                    mismatches;

        function new();
            width_reg  = CFG_DATA_W'(IMAGE_WIDTH_RESET);
            height_reg = CFG_DATA_W'(IMAGE_HEIGHT_RESET);
            foreach (older_row[i]) begin
                older_row[i]  = '0;
                recent_row[i] = '0;
            end
            pixels_checked = 0;
            mismatches     = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (win[i]) win[i] = '0;
            in_col = 0;
            in_row = 0;
        endfunction

        function int clamp_dim(logic [CFG_DATA_W-1:0] v);
            if (v < 2) return 2;
            if (v > DIM_LIMIT) return DIM_LIMIT;
            return int'(v);
        endfunction

        function int frame_width();
            return clamp_dim(width_reg);
        endfunction

        function int frame_height();
            return clamp_dim(height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == REG_IMAGE_WIDTH) begin
                width_reg = value;
                restart_frame();
            end else if (index == REG_IMAGE_HEIGHT) begin
                height_reg = value;
                restart_frame();
            end
        endfunction

        // Bilinear pixel at (orow, ocol); cl, cc, cr pick the window columns for
        // left, center and right, so the left edge is replicated by the caller.
        function pixel_t interpolate(int orow, int ocol, int cl, int cc, int cr, int w, int h);
            int ul, up, ur, lf, ce, rt, dl, dn, dr;
            int plus4, diag, horiz, vert;
            int red, green, blue;
            pixel_t px;
            ul = win[cl];
            up = win[cc];
            ur = win[cr];
            lf = win[3 + cl];
            ce = win[3 + cc];
            rt = win[3 + cr];
            dl = win[6 + cl];
            dn = win[6 + cc];
            dr = win[6 + cr];
            // replicate the middle row past the top and bottom borders
            if (orow == 0) begin
                ul = lf;
                up = ce;
                ur = rt;
            end
            if (orow == h - 1) begin
                dl = lf;
                dn = ce;
                dr = rt;
            end
            plus4 = (lf + rt + up + dn) >> 2;
            diag  = (ul + ur + dl + dr) >> 2;
            horiz = (lf + rt) >> 1;
            vert  = (up + dn) >> 1;
            case ({orow[0], ocol[0]})
                2'b00: begin
                    red   = ce;
                    green = plus4;
                    blue  = diag;
                end
                2'b01: begin
                    green = ce;
                    red   = horiz;
                    blue  = vert;
                end
                2'b10: begin
                    green = ce;
                    red   = vert;
                    blue  = horiz;
                end
                default: begin
                    blue  = ce;
                    green = plus4;
                    red   = diag;
                end
            endcase
            px.red   = PIX_W'(red);
            px.green = PIX_W'(green);
            px.blue  = PIX_W'(blue);
            px.last  = (orow == h - 1) && (ocol == w - 1);
            return px;
        endfunction

        // Advance the raster position for one accepted transfer and queue its pixel.
        function void note_item(logic drain, logic [PIX_W-1:0] sample);
            int w, h, x, r, i;
            logic [PIX_W-1:0] top, mid, bot;
            w = frame_width();
            h = frame_height();
            x = in_col;
            r = in_row;
            // drop samples after the frame's last sample and drains mid-frame
            if (!drain && r >= h) return;
            if (drain && r < h) return;
            if (x == 0 && r >= 2)
                pending_pixels.push_back(interpolate(r - 2, w - 1, 1, 2, 2, w, h));
            if (r > h) begin
                restart_frame();
                return;
            end
            top = older_row[x];
            mid = recent_row[x];
            bot = drain ? '0 : sample;
            older_row[x]  = mid;
            recent_row[x] = bot;
            for (i = 0; i < 3; i++) begin
                win[3*i]     = win[3*i + 1];
                win[3*i + 1] = win[3*i + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = bot;
            if (x >= 1 && r >= 1)
                pending_pixels.push_back(interpolate(r - 1, x - 1, (x == 1) ? 1 : 0, 1, 2, w, h));
            x++;
            if (x >= w) begin
                x = 0;
                r++;
            end
            in_col = x;
            in_row = r;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            // keep the log short when a bug repeats on every pixel
            if (mismatches <= REPORT_LIMIT) $display("mismatch %0d: %s", mismatches, msg);
        endtask

        task compare_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("pixel %0d %s got %h, expected %h",
                                          pixels_checked, name, got, want));
        endtask

        task check_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                         logic [PIX_W-1:0] blue, logic last);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %0d arrived with none predicted",
                                          pixels_checked));
                pixels_checked++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red", red, want.red);
            compare_field("green", green, want.green);
            compare_field("blue", blue, want.blue);
            compare_field("frame_last", PIX_W'(last), PIX_W'(want.last));
            pixels_checked++;
        endtask
    endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for the Bayer bilinear demosaic block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbd_pkg::*;
    import demosaic_scoreboard_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     LONG_HOLD     = 300;
    localparam int     RANDOM_ITEMS  = 450;
    localparam longint LIMIT_CYCLES  = 6_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [3*PIX_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    demosaic_scoreboard sb;
    bit                 stall_request;
    bit                 send_steady;
    bit                 take_steady;
    int                 counted_items;

    bayer_bilinear_demosaic u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

    // Mostly short idle stretches, now and then a long one.
    function int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function int pick_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(0, 1);
        if (r == 1) return $urandom_range(10, 24);
        return $urandom_range(2, 8);
    endfunction

    function int pick_height(bit tall);
        if (tall && $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
                0: return DIM_LIMIT;
                1: return 8191;
                default: return $urandom_range(7, 8191);
            endcase
        end
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1);
        return $urandom_range(2, 6);
    endfunction

    task send_item(logic drain, logic [PIX_W-1:0] sample);
        int gap;
        gap = 0;
        if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
        if (!send_steady && $urandom_range(0, 2) == 0) gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= drain;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the input, let the last transfer reach the scoreboard, then wait out
    // every predicted pixel and the pipeline behind it.
    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_reg(index, value);
    endtask

    task configure(int w_value, int h_value);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_value));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_value));
    endtask

    task send_samples(int count);
        repeat (count) begin
            send_item(1'b0, PIX_W'($urandom_range(0, 255)));
            counted_items++;
        end
    endtask

    // One whole frame plus its drains; with noise, mix in transfers the block drops.
    task send_frame(bit noisy);
        int w, h;
        w = sb.frame_width();
        h = sb.frame_height();
        repeat (w * h) begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(1'b1, PIX_W'($urandom_range(0, 255)));
            send_item(1'b0, PIX_W'($urandom_range(0, 255)));
            counted_items++;
        end
        repeat (w + 1) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(1'b0, PIX_W'($urandom_range(0, 255)));
            send_item(1'b1, PIX_W'($urandom_range(0, 255)));
            counted_items++;
        end
    endtask

    // Result side: random stalls, steady stretches, and one long hold-off on request.
    initial begin
        int hold_left;
        int cycles;
        hold_left = 0;
        cycles    = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles % 64 == 0) take_steady = ($urandom_range(0, 3) == 0);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end else if (take_steady || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
            end else begin
                hold_left = gap_length() - 1;
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata[PIX_W-1:0], m_tdata[2*PIX_W-1:PIX_W],
                               m_tdata[3*PIX_W-1:2*PIX_W], m_tlast);
            if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
        end
    end

    initial begin
        int  i;
        int  w_value;
        int  h_value;
        int  count;
        bit  partial;
        bit  restart_pending;

        sb = new();
        stall_request = 1'b0;
        send_steady   = 1'b0;
        take_steady   = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Widest row of the random frames first, so later frames read line-store
        // entries already written. Hold the output early so the queue fills and
        // the input stalls.
        configure(24, 3);
        stall_request = 1'b1;
        send_frame(1'b0);

        // Smallest frame: drains mid-frame and samples while draining are dropped.
        configure(1, 2);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h5A);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hA5);
        send_item(1'b1, 8'h00);

        // 3x3 frame walking a single set bit through the samples.
        configure(3, 3);
        for (i = 0; i < PIX_W; i++) send_item(1'b0, PIX_W'(1 << i));
        send_item(1'b0, 8'hFF);
        repeat (4) send_item(1'b1, 8'h00);

        // Out-of-range register values clamp to the limits; each write restarts the frame.
        configure(8191, 1);
        send_samples(40);
        configure(0, 8191);
        send_samples(60);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(DIM_LIMIT));
        send_samples(30);

        configure(pick_width(), pick_height(1'b0));
        counted_items   = 0;
        restart_pending = 1'b0;
        while (counted_items < RANDOM_ITEMS) begin
            partial = ($urandom_range(0, 4) == 0);
            if (partial || restart_pending || $urandom_range(0, 1) == 0) begin
                w_value = pick_width();
                h_value = pick_height(partial);
                case ($urandom_range(0, 3))
                    0: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_value));
                    1: write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_value));
                    default: configure(w_value, h_value);
                endcase
            end
            // keep whole frames small after a tall partial one
            if (!partial && sb.frame_height() > 8)
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(pick_height(1'b0)));
            restart_pending = 1'b0;
            if (partial) begin
                count = sb.frame_width() * sb.frame_height() - 1;
                if (count > 5 * sb.frame_width()) count = 5 * sb.frame_width();
                send_samples($urandom_range(1, count));
                restart_pending = 1'b1;
            end else begin
                send_frame(1'b1);
            end
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bbd_pkg.sv
rtl/bbd_ram.sv
rtl/bbd_front.sv
rtl/bbd_queue.sv
rtl/bbd_back.sv
rtl/bayer_bilinear_demosaic.sv
tb/demosaic_scoreboard_pkg.sv
tb/testbench.sv
